// File: sv/utf8ws_pkg.sv
package utf8ws_pkg;

  localparam int MAX_BOLD     = 9;
  localparam int RUN_LEN_BITS = 16;
  localparam int BOLD_IDX_W   = (MAX_BOLD > 1) ? $clog2(MAX_BOLD) : 1;

  localparam int CP_W       = 21;
  localparam int NB_W       = 3;
  localparam int OFS_W      = 6;
  localparam int CNT_W      = 16;
  localparam int PCT_W      = 7;
  localparam int MAXB_W     = 4;
  localparam int PROD_W     = CNT_W + PCT_W;
  localparam int RB_W       = 16;
  localparam int BB_W       = 8;
  localparam int BYTE_W     = 8;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 7;
  localparam int M_TDATA_W  = 32;
  localparam int Q_DEPTH    = 4;
  localparam int Q_PTR_W    = 2;
  localparam int PCT_SCALE  = 100;

  localparam logic [CP_W-1:0]   CP_REPLACE      = 21'h00FFFD;
  localparam logic              FOCUS_RESET     = 1'b1;
  localparam logic [PCT_W-1:0]  PERCENT_RESET   = 7'd45;
  localparam logic [MAXB_W-1:0] MAX_BOLD_RESET  = 4'd9;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FOCUS    = 2'd0,
    REG_PERCENT  = 2'd1,
    REG_MAX_BOLD = 2'd2
  } cfg_reg_t;

  typedef struct packed {
    logic              focus;
    logic [PCT_W-1:0]  pct;
    logic [MAXB_W-1:0] max_bold;
  } cfg_t;

  typedef struct packed {
    logic            valid;
    logic            is_word;
    logic [NB_W-1:0] nbytes;
  } cp_evt_t;

  typedef struct packed {
    logic [RB_W-1:0] run_bytes;
    logic            is_word;
    logic [BB_W-1:0] bold_bytes;
    logic            whole_bold;
    logic            final_run;
  } run_res_t;

  function automatic logic word_class(input logic [CP_W-1:0] cp);
    logic [6:0] low;
    logic       w;
    low = cp[6:0] | 7'h20;
    if (cp < 21'h80) begin
      w = (low inside {[7'h61:7'h7A]}) || (cp == 21'h27);
    end else if (cp inside {[21'h2000:21'h2BFF]}) begin
      w = (cp == 21'h2018) || (cp == 21'h2019);
    end else if (cp inside {[21'h00A1:21'h00BF]}) begin
      w = cp inside {21'h00AA, 21'h00B5, 21'h00BA};
    end else if (cp inside {[21'h2E00:21'h2E7F]}) begin
      w = 1'b0;
    end else if (cp inside {21'h02D7, 21'hFE63, 21'hFF0D}) begin
      w = 1'b0;
    end else begin
      w = 1'b1;
    end
    return w;
  endfunction

endpackage

// File: sv/utf8_word_segment_bold_split.sv
// Timing: an accepted byte is held in the input register and is processed once the
//   output queue has room; its result words are registered in that queue.
// Throughput: one byte per cycle while the 4-entry output queue has room; a byte
//   that closes a run and also ends the text yields two words, pushed together.
// Reset: clears decoder, run state and queue; focus_enable=1, bold_percent=45,
//   max_bold_chars=9.
module utf8_word_segment_bold_split
  import utf8ws_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [BYTE_W-1:0]     s_tdata,   // [7:0] data_byte
  input  logic                  s_tlast,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [M_TDATA_W-1:0]  m_tdata,   // [15:0] run_bytes, [23:16] bold_bytes,
                                           // [24] whole_bold, [31:25] zero
  output logic                  m_tuser,   // [0] is_word
  output logic                  m_tlast,
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  logic              focus_enable;
  logic [PCT_W-1:0]  bold_percent;
  logic [MAXB_W-1:0] max_bold_chars;
  cfg_t              cfg;

  logic              in_valid;
  logic [BYTE_W-1:0] in_byte;
  logic              in_eot;
  logic              adv;
  logic              q_room;

  cp_evt_t           cp_evt;
  logic              res_a_valid, res_b_valid;
  run_res_t          res_a, res_b, head;

  always_ff @(posedge clk) begin
    if (rst) begin
      focus_enable   <= FOCUS_RESET;
      bold_percent   <= PERCENT_RESET;
      max_bold_chars <= MAX_BOLD_RESET;
    end else if (cfg_wr_en) begin
      case (cfg_reg_t'(cfg_index))
        REG_FOCUS:    focus_enable   <= cfg_data[0];
        REG_PERCENT:  bold_percent   <= cfg_data[PCT_W-1:0];
        REG_MAX_BOLD: max_bold_chars <= cfg_data[MAXB_W-1:0];
        default: ;
      endcase
    end
  end

  assign cfg.focus    = focus_enable;
  assign cfg.pct      = bold_percent;
  assign cfg.max_bold = max_bold_chars;

  assign adv      = in_valid && q_room;
  assign s_tready = !in_valid || adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      in_valid <= 1'b1;
    end else if (adv) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_byte <= s_tdata;
      in_eot  <= s_tlast;
    end
  end

  utf8ws_decode u_decode (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .data_byte (in_byte),
    .eot       (in_eot),
    .cp_evt    (cp_evt)
  );

  utf8ws_run u_run (
    .clk         (clk),
    .rst         (rst),
    .adv         (adv),
    .eot         (in_eot),
    .cp_evt      (cp_evt),
    .cfg         (cfg),
    .res_a_valid (res_a_valid),
    .res_a       (res_a),
    .res_b_valid (res_b_valid),
    .res_b       (res_b)
  );

  utf8ws_oq u_oq (
    .clk        (clk),
    .rst        (rst),
    .push_a     (res_a_valid),
    .data_a     (res_a),
    .push_b     (res_b_valid),
    .data_b     (res_b),
    .pop        (m_tready),
    .room       (q_room),
    .head_valid (m_tvalid),
    .head       (head)
  );

  assign m_tdata = {(M_TDATA_W - RB_W - BB_W - 1)'(0), head.whole_bold,
                    head.bold_bytes, head.run_bytes};
  assign m_tuser = head.is_word;
  assign m_tlast = head.final_run;

endmodule

// File: sv/utf8ws_decode.sv
module utf8ws_decode
  import utf8ws_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              adv,
  input  logic [BYTE_W-1:0] data_byte,
  input  logic              eot,
  output cp_evt_t           cp_evt
);

  logic [CP_W-1:0] code_accum, code_accum_next;
  logic [1:0]      bytes_pending, bytes_pending_next;
  logic [NB_W-1:0] code_byte_count, code_byte_count_next;
  logic            seq_bad, seq_bad_next;
  logic            cont;
  logic            cp_valid;
  logic [CP_W-1:0] cp_val;
  logic [NB_W-1:0] cp_nb;

  always_comb begin
    code_accum_next      = code_accum;
    bytes_pending_next   = bytes_pending;
    code_byte_count_next = code_byte_count;
    seq_bad_next         = seq_bad;
    cp_valid             = 1'b0;
    cp_val               = '0;
    cp_nb                = '0;
    cont                 = (data_byte[7:6] == 2'b10);

    if (bytes_pending != 2'd0) begin
      if (cont) begin
        code_accum_next = {code_accum[CP_W-7:0], data_byte[5:0]};
      end
      seq_bad_next         = seq_bad | ~cont;
      code_byte_count_next = code_byte_count + NB_W'(1);
      bytes_pending_next   = bytes_pending - 2'd1;
      if (bytes_pending_next == 2'd0) begin
        cp_valid             = 1'b1;
        cp_val               = seq_bad_next ? CP_REPLACE : code_accum_next;
        cp_nb                = code_byte_count_next;
        code_accum_next      = '0;
        code_byte_count_next = '0;
        seq_bad_next         = 1'b0;
      end
    end else if (data_byte < 8'h80) begin
      cp_valid = 1'b1;
      cp_val   = CP_W'(data_byte);
      cp_nb    = NB_W'(1);
    end else if (data_byte inside {[8'hC2:8'hDF]}) begin
      code_accum_next      = CP_W'(data_byte[4:0]);
      bytes_pending_next   = 2'd1;
      code_byte_count_next = NB_W'(1);
      seq_bad_next         = 1'b0;
    end else if (data_byte inside {[8'hE0:8'hEF]}) begin
      code_accum_next      = CP_W'(data_byte[3:0]);
      bytes_pending_next   = 2'd2;
      code_byte_count_next = NB_W'(1);
      seq_bad_next         = 1'b0;
    end else if (data_byte inside {[8'hF0:8'hF4]}) begin
      code_accum_next      = CP_W'(data_byte[2:0]);
      bytes_pending_next   = 2'd3;
      code_byte_count_next = NB_W'(1);
      seq_bad_next         = 1'b0;
    end else begin
      cp_valid = 1'b1;
      cp_val   = CP_REPLACE;
      cp_nb    = NB_W'(1);
    end

    if (eot) begin
      if (bytes_pending_next != 2'd0) begin
        cp_valid = 1'b1;
        cp_val   = CP_REPLACE;
        cp_nb    = code_byte_count_next;
      end
      code_accum_next      = '0;
      bytes_pending_next   = '0;
      code_byte_count_next = '0;
      seq_bad_next         = 1'b0;
    end

    cp_evt.valid   = adv & cp_valid;
    cp_evt.is_word = word_class(cp_val);
    cp_evt.nbytes  = cp_nb;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      code_accum      <= '0;
      bytes_pending   <= '0;
      code_byte_count <= '0;
      seq_bad         <= 1'b0;
    end else if (adv) begin
      code_accum      <= code_accum_next;
      bytes_pending   <= bytes_pending_next;
      code_byte_count <= code_byte_count_next;
      seq_bad         <= seq_bad_next;
    end
  end

  a_eot_clears: assert property (@(posedge clk) disable iff (rst)
    adv && eot |=> bytes_pending == 2'd0 && code_byte_count == '0)
    else $error("decoder not cleared after end of text");

endmodule

// File: sv/utf8ws_run.sv
module utf8ws_run
  import utf8ws_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     adv,
  input  logic     eot,
  input  cp_evt_t  cp_evt,
  input  cfg_t     cfg,
  output logic     res_a_valid,
  output run_res_t res_a,
  output logic     res_b_valid,
  output run_res_t res_b
);

  localparam int RL_EXT_W = (RUN_LEN_BITS > RB_W) ? RUN_LEN_BITS : RB_W;

  logic                    type_known;
  logic                    run_is_word;
  logic [RUN_LEN_BITS-1:0] run_length;
  logic [CNT_W-1:0]        char_count;
  logic [OFS_W-1:0]        char_end_offsets [MAX_BOLD];

  logic                    closed;
  logic                    mid_known, mid_word;
  logic [RUN_LEN_BITS-1:0] base_len, mid_len;
  logic [RUN_LEN_BITS:0]   len_sum;
  logic [CNT_W-1:0]        base_cnt, mid_cnt;
  logic [OFS_W-1:0]        char_end_offsets_next [MAX_BOLD];

  logic                    sel_word;
  logic [RUN_LEN_BITS-1:0] sel_len;
  logic [CNT_W-1:0]        sel_cnt;
  logic [OFS_W-1:0]        sel_ofs;
  logic [RL_EXT_W-1:0]     len_ext;
  logic [PROD_W-1:0]       prod;
  logic [MAXB_W-1:0]       m_lim, t_cnt, t_idx;
  logic                    active, whole;

  always_comb begin
    closed   = cp_evt.valid && type_known && (cp_evt.is_word != run_is_word);
    base_len = closed ? '0 : run_length;
    base_cnt = closed ? '0 : char_count;
    mid_known = closed ? 1'b0 : type_known;
    mid_word  = closed ? 1'b0 : run_is_word;
    mid_len   = base_len;
    mid_cnt   = base_cnt;
    len_sum   = '0;
    char_end_offsets_next = char_end_offsets;
    if (cp_evt.valid) begin
      mid_known = 1'b1;
      mid_word  = cp_evt.is_word;
      len_sum   = {1'b0, base_len} + (RUN_LEN_BITS+1)'(cp_evt.nbytes);
      mid_len   = len_sum[RUN_LEN_BITS] ? '1 : len_sum[RUN_LEN_BITS-1:0];
      if (base_cnt < CNT_W'(MAX_BOLD)) begin
        char_end_offsets_next[base_cnt[BOLD_IDX_W-1:0]] = mid_len[OFS_W-1:0];
      end
      if (base_cnt != '1) begin
        mid_cnt = base_cnt + CNT_W'(1);
      end
    end
  end

  always_comb begin
    sel_word = closed ? run_is_word : mid_word;
    sel_len  = closed ? run_length  : mid_len;
    sel_cnt  = closed ? char_count  : mid_cnt;
    len_ext  = RL_EXT_W'(sel_len);
    prod     = PROD_W'(sel_cnt) * PROD_W'(cfg.pct);

    if (cfg.max_bold == '0) begin
      m_lim = MAXB_W'(1);
    end else if (cfg.max_bold > MAXB_W'(MAX_BOLD)) begin
      m_lim = MAXB_W'(MAX_BOLD);
    end else begin
      m_lim = cfg.max_bold;
    end

    t_cnt = MAXB_W'(1);
    for (int k = 2; k <= MAX_BOLD; k++) begin
      if (MAXB_W'(k) <= m_lim && prod >= PROD_W'(PCT_SCALE * k)) begin
        t_cnt = MAXB_W'(k);
      end
    end
    t_idx = t_cnt - MAXB_W'(1);
    sel_ofs = closed ? char_end_offsets[t_idx[BOLD_IDX_W-1:0]]
                     : char_end_offsets_next[t_idx[BOLD_IDX_W-1:0]];

    active = cfg.focus && sel_word && (sel_cnt != '0);
    whole  = active && (CNT_W'(t_cnt) >= sel_cnt);

    res_a.run_bytes  = (len_ext > RL_EXT_W'({RB_W{1'b1}})) ? '1 : len_ext[RB_W-1:0];
    res_a.is_word    = sel_word;
    res_a.whole_bold = whole;
    res_a.final_run  = eot && !closed;
    if (!active) begin
      res_a.bold_bytes = '0;
    end else if (whole) begin
      res_a.bold_bytes = (len_ext > RL_EXT_W'({BB_W{1'b1}})) ? '1 : len_ext[BB_W-1:0];
    end else begin
      res_a.bold_bytes = BB_W'(sel_ofs);
    end
    res_a_valid = adv && (closed || eot);

    res_b.run_bytes  = RB_W'(cp_evt.nbytes);
    res_b.is_word    = cp_evt.is_word;
    res_b.whole_bold = cfg.focus && cp_evt.is_word;
    res_b.bold_bytes = res_b.whole_bold ? BB_W'(cp_evt.nbytes) : '0;
    res_b.final_run  = 1'b1;
    res_b_valid      = adv && closed && eot;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      type_known  <= 1'b0;
      run_is_word <= 1'b0;
      run_length  <= '0;
      char_count  <= '0;
    end else if (adv) begin
      if (eot) begin
        type_known  <= 1'b0;
        run_is_word <= 1'b0;
        run_length  <= '0;
        char_count  <= '0;
      end else begin
        type_known  <= mid_known;
        run_is_word <= mid_word;
        run_length  <= mid_len;
        char_count  <= mid_cnt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      char_end_offsets <= char_end_offsets_next;
    end
  end

  a_b_after_a: assert property (@(posedge clk) disable iff (rst)
    res_b_valid |-> res_a_valid && !res_a.final_run)
    else $error("final run word without closed run word");

  a_whole_word: assert property (@(posedge clk) disable iff (rst)
    res_a_valid && res_a.whole_bold |-> res_a.is_word && cfg.focus)
    else $error("whole bold on non-word run");

  a_eot_clears: assert property (@(posedge clk) disable iff (rst)
    adv && eot |=> !type_known && char_count == '0)
    else $error("run state not cleared after end of text");

endmodule

// File: sv/utf8ws_oq.sv
module utf8ws_oq
  import utf8ws_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     push_a,
  input  run_res_t data_a,
  input  logic     push_b,
  input  run_res_t data_b,
  input  logic     pop,
  output logic     room,
  output logic     head_valid,
  output run_res_t head
);

  run_res_t           entries [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr, rd_ptr;
  logic [Q_PTR_W:0]   count, count_next;
  logic [Q_PTR_W-1:0] wr_ptr_b;
  logic               do_pop;

  assign do_pop     = pop && head_valid;
  assign head_valid = (count != '0);
  assign head       = entries[rd_ptr];
  assign room       = (count <= (Q_PTR_W+1)'(Q_DEPTH - 2));
  assign wr_ptr_b   = wr_ptr + Q_PTR_W'(1);
  assign count_next = count + (Q_PTR_W+1)'(push_a) + (Q_PTR_W+1)'(push_b)
                    - (Q_PTR_W+1)'(do_pop);

  always_ff @(posedge clk) begin
    if (push_a) begin
      entries[wr_ptr] <= data_a;
    end
    if (push_b) begin
      entries[wr_ptr_b] <= data_b;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + Q_PTR_W'(push_a) + Q_PTR_W'(push_b);
      rd_ptr <= rd_ptr + Q_PTR_W'(do_pop);
      count  <= count_next;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    count <= (Q_PTR_W+1)'(Q_DEPTH))
    else $error("output queue overflow");

  a_push_order: assert property (@(posedge clk) disable iff (rst)
    push_b |-> push_a && $past(count) == $past(count))
    else $error("second slot pushed without first");

endmodule
